// ===== sv/lattice_value_noise_3d_assert.svh =====
// Assertion macros shared by the noise block.
// Both sample on clk and are switched off while arst_n is low.
`ifndef LATTICE_VALUE_NOISE_3D_ASSERT_SVH
`define LATTICE_VALUE_NOISE_3D_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define LVN_ASSERT_SAME(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error(msg);

// Condition a implies condition b in the following cycle.
`define LVN_ASSERT_NEXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error(msg);

`endif

// ===== sv/lvn_pkg.sv =====
// ----------------------------------------------------------------------------
// lvn_pkg
// Shared constants, types and helpers for the lattice value noise block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lvn_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int SCALE_FRAC  = 16;
	localparam int TABLE_DEPTH = 16384;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COORD_W     = 32;
	localparam int SCALE_W     = 32;
	localparam int INT_W       = COORD_W - FRAC_BITS + 1;
	localparam int HASH_W      = INT_W + SCALE_W + 1;
	localparam int SUM_W       = HASH_W + 2;
	localparam int WORD_W      = 16;
	localparam int W_W         = FRAC_BITS + 1;
	localparam int MAG_W       = WORD_W + 1;
	localparam int OUT_W       = 18;
	localparam int ACC_W       = MAG_W + 4;
	localparam int NUM_AXES    = 3;
	localparam int CIDX_W      = 2;

	localparam logic [W_W-1:0]   ONE_W   = W_W'(1) << FRAC_BITS;
	localparam logic [W_W-1:0]   HALF_W  = W_W'(1) << (FRAC_BITS - 1);
	localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << WORD_W;

	localparam logic [SCALE_W-1:0] SCALE_X_RESET = 32'd20588724;
	localparam logic [SCALE_W-1:0] SCALE_Y_RESET = 32'd40503411;
	localparam logic [SCALE_W-1:0] SCALE_Z_RESET = 32'd9268167;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_SCALE_X = 2'd0,
		REG_SCALE_Y = 2'd1,
		REG_SCALE_Z = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN,
		BK_HOLD
	} back_state_t;

	// One classified item as it sits in the queue between front and back.
	typedef struct packed {
		cmd_t                               cmd;
		logic [ADDR_W-1:0]                  index;
		logic [WORD_W-1:0]                  value;
		logic [NUM_AXES-1:0][HASH_W-1:0]    h_lo;
		logic [NUM_AXES-1:0][HASH_W-1:0]    h_hi;
		logic [NUM_AXES-1:0][W_W-1:0]       w;
	} item_t;

	// Magnitude times a weight, shifted down and truncated.
	function automatic logic [MAG_W-1:0] mul_weight(input logic [MAG_W-1:0] mag,
			input logic [W_W-1:0] wt);
		logic [MAG_W+W_W-1:0] prod;
		prod = mag * wt;
		return prod[FRAC_BITS +: MAG_W];
	endfunction

endpackage

`default_nettype wire

// ===== sv/lvn_front.sv =====
// ----------------------------------------------------------------------------
// lvn_front
// Accepts items, splits each coordinate and works out per-axis hash terms
// and eased weights ahead of the table lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lvn_front (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         in_valid,
	output logic                                              in_ready,
	input  wire logic                                         cmd,
	input  wire logic [lvn_pkg::ADDR_W-1:0]                   table_index,
	input  wire logic [lvn_pkg::WORD_W-1:0]                   table_value,
	input  wire logic [lvn_pkg::NUM_AXES-1:0][lvn_pkg::COORD_W-1:0] coord,
	input  wire logic [lvn_pkg::NUM_AXES-1:0][lvn_pkg::SCALE_W-1:0] scale,
	output logic                                              push_valid,
	input  wire logic                                         push_ready,
	output lvn_pkg::item_t                                    push_item
);

	logic                                              v_s1;
	lvn_pkg::cmd_t                                     cmd_s1;
	logic [lvn_pkg::ADDR_W-1:0]                        index_s1;
	logic [lvn_pkg::WORD_W-1:0]                        value_s1;
	logic [lvn_pkg::NUM_AXES-1:0][lvn_pkg::COORD_W-1:0] coord_s1;

	// The input register frees as soon as the queue takes its content.
	assign in_ready   = !v_s1 || push_ready;
	assign push_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Capture the payload on each input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= lvn_pkg::cmd_t'(cmd);
			index_s1 <= table_index;
			value_s1 <= table_value;
			coord_s1 <= coord;
		end
	end

	assign push_item.cmd   = cmd_s1;
	assign push_item.index = index_s1;
	assign push_item.value = value_s1;

	// Per axis: floor, hash term for the low and high corner, eased weight.
	for (genvar a = 0; a < lvn_pkg::NUM_AXES; a++) begin : g_axis
		logic signed [lvn_pkg::INT_W-1:0]    ip;
		logic [lvn_pkg::FRAC_BITS-1:0]       frac;
		logic signed [lvn_pkg::HASH_W-1:0]   lo;
		logic signed [lvn_pkg::HASH_W-1:0]   step;
		logic [lvn_pkg::W_W-1:0]             gap;
		logic                                frac_low;
		logic [lvn_pkg::FRAC_BITS-1:0]       sq_src;
		logic [2*lvn_pkg::FRAC_BITS-1:0]     sq;
		logic [lvn_pkg::W_W-1:0]             sq_sh;

		assign ip   = $signed({coord_s1[a][lvn_pkg::COORD_W-1],
				coord_s1[a][lvn_pkg::COORD_W-1:lvn_pkg::FRAC_BITS]});
		assign frac = coord_s1[a][lvn_pkg::FRAC_BITS-1:0];
		assign lo   = ip * $signed({1'b0, scale[a]});

		// The high corner sits one step further when the fraction is nonzero.
		assign step = (frac != '0) ?
				$signed({{(lvn_pkg::HASH_W-lvn_pkg::SCALE_W){1'b0}}, scale[a]}) : '0;
		assign push_item.h_lo[a] = lo;
		assign push_item.h_hi[a] = lo + step;

		// Quadratic easing: 2f^2 up to one half, mirrored above it.
		assign gap      = lvn_pkg::ONE_W - {1'b0, frac};
		assign frac_low = {1'b0, frac} <= lvn_pkg::HALF_W;
		assign sq_src   = frac_low ? frac : gap[lvn_pkg::FRAC_BITS-1:0];
		assign sq       = sq_src * sq_src;
		assign sq_sh    = sq[2*lvn_pkg::FRAC_BITS-1:lvn_pkg::FRAC_BITS-1];
		assign push_item.w[a] = frac_low ? sq_sh : (lvn_pkg::ONE_W - sq_sh);
	end

endmodule

`default_nettype wire

// ===== sv/lvn_queue.sv =====
// ----------------------------------------------------------------------------
// lvn_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lvn_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire lvn_pkg::item_t  push_item,
	output logic                 q_valid,
	input  wire logic            q_pop,
	output lvn_pkg::item_t       q_item
);

	lvn_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;

	assign push_ready = count_q != 2'd2;
	assign q_valid    = count_q != 2'd0;
	assign q_item     = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(q_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/lvn_back.sv =====
// ----------------------------------------------------------------------------
// lvn_back
// Owns the random table. Performs table writes and, for each point, reads
// the eight corner words one per cycle and blends them through a pipeline
// of three weight multipliers into an accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lattice_value_noise_3d_assert.svh"

module lvn_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	output logic                               q_pop,
	input  wire lvn_pkg::item_t                q_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [lvn_pkg::OUT_W-1:0]   noise_value
);

	lvn_pkg::back_state_t state_q, state_d;
	logic [2:0]           corner_q;
	logic                 mem_we, start, issue, load_out;

	logic [lvn_pkg::WORD_W-1:0] mem [lvn_pkg::TABLE_DEPTH];
	logic [lvn_pkg::ADDR_W-1:0] rd_addr;

	logic                          v_s2, v_s3, v_s4, v_s5;
	logic [2:0]                    k_s2, k_s3, k_s4, k_s5;
	logic [lvn_pkg::WORD_W-1:0]    word_s2;
	logic                          neg_s3, neg_s4, neg_s5;
	logic [lvn_pkg::MAG_W-1:0]     mag_s3, mag_s4, mag_s5;

	logic signed [lvn_pkg::ACC_W-1:0] acc_q;
	logic signed [lvn_pkg::ACC_W-1:0] term;
	logic                             last_term;
	logic                             out_valid_q;
	logic signed [lvn_pkg::OUT_W-1:0] noise_q;

	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;
	assign last_term   = v_s5 && (k_s5 == 3'd7);

	// Hash of the current corner: sum of the chosen per-axis terms, integer
	// part truncated toward zero, low bits kept as the table address.
	logic [lvn_pkg::NUM_AXES-1:0][lvn_pkg::HASH_W-1:0] pick;
	logic signed [lvn_pkg::SUM_W-1:0] hsum;
	logic                             round_up;

	for (genvar a = 0; a < lvn_pkg::NUM_AXES; a++) begin : g_pick
		assign pick[a] = corner_q[a] ? q_item.h_hi[a] : q_item.h_lo[a];
	end

	assign hsum = lvn_pkg::SUM_W'($signed(pick[0])) + lvn_pkg::SUM_W'($signed(pick[1]))
			+ lvn_pkg::SUM_W'($signed(pick[2]));
	assign round_up = hsum[lvn_pkg::SUM_W-1] && (hsum[lvn_pkg::SCALE_FRAC-1:0] != '0);
	assign rd_addr  = hsum[lvn_pkg::SCALE_FRAC +: lvn_pkg::ADDR_W]
			+ lvn_pkg::ADDR_W'(round_up);

	// Control: next state and strobes.
	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		start    = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		q_pop    = 1'b0;
		case (state_q)
			lvn_pkg::BK_IDLE: begin
				if (q_valid) begin
					if (q_item.cmd == lvn_pkg::CMD_WRITE) begin
						mem_we = 1'b1;
						q_pop  = 1'b1;
					end else begin
						start   = 1'b1;
						state_d = lvn_pkg::BK_ISSUE;
					end
				end
			end
			lvn_pkg::BK_ISSUE: begin
				issue = 1'b1;
				if (corner_q == 3'd7) begin
					state_d = lvn_pkg::BK_DRAIN;
				end
			end
			lvn_pkg::BK_DRAIN: begin
				if (last_term) begin
					state_d = lvn_pkg::BK_HOLD;
				end
			end
			lvn_pkg::BK_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					q_pop    = 1'b1;
					state_d  = lvn_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lvn_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvn_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Corner counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= 3'd0;
		end else if (start) begin
			corner_q <= 3'd0;
		end else if (issue) begin
			corner_q <= corner_q + 3'd1;
		end
	end

	// Single-port table: writes when idle, one corner read per issue cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_item.index] <= q_item.value;
		end
		if (issue) begin
			word_s2 <= mem[rd_addr];
		end
	end

	// Valid bits of the blend pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= issue;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Map the word to [-1,1) as sign and magnitude, then weight per axis.
	logic [lvn_pkg::MAG_W-1:0] twice;
	logic                      neg_word;
	logic [lvn_pkg::MAG_W-1:0] mag_word;

	assign twice    = {word_s2, 1'b0};
	assign neg_word = !word_s2[lvn_pkg::WORD_W-1];
	assign mag_word = neg_word ? (lvn_pkg::ONE_MAG - twice) : (twice - lvn_pkg::ONE_MAG);

	function automatic logic [lvn_pkg::W_W-1:0] pick_weight(input logic sel,
			input logic [lvn_pkg::W_W-1:0] wt);
		return sel ? wt : (lvn_pkg::ONE_W - wt);
	endfunction

	always_ff @(posedge clk) begin
		k_s2   <= corner_q;
		k_s3   <= k_s2;
		neg_s3 <= neg_word;
		mag_s3 <= lvn_pkg::mul_weight(mag_word, pick_weight(k_s2[0], q_item.w[0]));
		k_s4   <= k_s3;
		neg_s4 <= neg_s3;
		mag_s4 <= lvn_pkg::mul_weight(mag_s3, pick_weight(k_s3[1], q_item.w[1]));
		k_s5   <= k_s4;
		neg_s5 <= neg_s4;
		mag_s5 <= lvn_pkg::mul_weight(mag_s4, pick_weight(k_s4[2], q_item.w[2]));
	end

	// Accumulate the signed corner terms.
	assign term = neg_s5 ? -$signed(lvn_pkg::ACC_W'(mag_s5)) : $signed(lvn_pkg::ACC_W'(mag_s5));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (start) begin
			acc_q <= '0;
		end else if (v_s5) begin
			acc_q <= acc_q + term;
		end
	end

	// Output register with saturation to plus or minus one.
	logic signed [lvn_pkg::ACC_W-1:0] sat_hi, sat_lo;
	logic signed [lvn_pkg::OUT_W-1:0] sat;

	assign sat_hi = $signed(lvn_pkg::ACC_W'(lvn_pkg::ONE_MAG));
	assign sat_lo = -sat_hi;
	assign sat    = (acc_q > sat_hi) ? lvn_pkg::OUT_W'(sat_hi) :
			(acc_q < sat_lo) ? lvn_pkg::OUT_W'(sat_lo) : lvn_pkg::OUT_W'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			noise_q <= sat;
		end
	end

	`LVN_ASSERT_SAME(a_issue_has_eval, issue, q_valid && (q_item.cmd == lvn_pkg::CMD_EVAL), "corner read without a point at the queue head")
	`LVN_ASSERT_SAME(a_pop_has_item, q_pop, q_valid, "queue popped while empty")
	`LVN_ASSERT_SAME(a_last_in_drain, last_term, state_q == lvn_pkg::BK_DRAIN, "last corner term outside drain")
	`LVN_ASSERT_NEXT(a_load_shows, load_out, out_valid_q, "loaded result not presented")

endmodule

`default_nettype wire

// ===== sv/lattice_value_noise_3d.sv =====
// The back end evaluates one point at a time: it reads the eight corner words
// from the single-port table and drains the four-stage blend pipeline before
// it takes the next item from the queue; a table write is done by the back
// end in its idle state.
// Reset: arst_n clears control and restores the scale registers; the table
// itself is not cleared and must be loaded before points are evaluated.
// ----------------------------------------------------------------------------
// lattice_value_noise_3d
// Three-dimensional lattice value noise with eased trilinear blending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lattice_value_noise_3d (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [lvn_pkg::CIDX_W-1:0]          cfg_index,
	input  wire logic [lvn_pkg::SCALE_W-1:0]         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                cmd,
	input  wire logic [lvn_pkg::ADDR_W-1:0]          table_index,
	input  wire logic [lvn_pkg::WORD_W-1:0]          table_value,
	input  wire logic signed [lvn_pkg::COORD_W-1:0]  coord_x,
	input  wire logic signed [lvn_pkg::COORD_W-1:0]  coord_y,
	input  wire logic signed [lvn_pkg::COORD_W-1:0]  coord_z,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [lvn_pkg::OUT_W-1:0]         noise_value
);

	logic [lvn_pkg::SCALE_W-1:0] scale_x_q, scale_y_q, scale_z_q;
	logic                        push_valid, push_ready, q_valid, q_pop;
	lvn_pkg::item_t              push_item, q_item;

	// Scale registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= lvn_pkg::SCALE_X_RESET;
			scale_y_q <= lvn_pkg::SCALE_Y_RESET;
			scale_z_q <= lvn_pkg::SCALE_Z_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lvn_pkg::REG_SCALE_X: begin
					scale_x_q <= cfg_data;
				end
				lvn_pkg::REG_SCALE_Y: begin
					scale_y_q <= cfg_data;
				end
				lvn_pkg::REG_SCALE_Z: begin
					scale_z_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	lvn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.table_index (table_index),
		.table_value (table_value),
		.coord       ({coord_z, coord_y, coord_x}),
		.scale       ({scale_z_q, scale_y_q, scale_x_q}),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	lvn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item)
	);

	lvn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.noise_value (noise_value)
	);

endmodule

`default_nettype wire
